// File: rtl/gfrs_pkg.sv
package gfrs_pkg;

   localparam int FORCE_W   = 31;
   localparam int VALUE_W   = 32;
   localparam int FUNC_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [FORCE_W-1:0] MAX_FORCE = {FORCE_W{1'b1}};

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_START   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_GRIP    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_NORMAL  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PREEMPT = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_RUNNING   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SUCCEEDED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PREEMPTED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CONTACT_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTACT_FORCE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP         = 2'd2;

   localparam logic [FORCE_W-1:0] RST_CONTACT_THRESHOLD = 31'd65536;
   localparam logic [FORCE_W-1:0] RST_CONTACT_FORCE     = 31'd196608;
   localparam logic [FORCE_W-1:0] RST_RAMP_STEP         = 31'd393;

   typedef struct packed {
      logic [FORCE_W-1:0]  force_cmd;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_item_type;

   // results of one processed item, written into the result queue together
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_push_type;

endpackage

// File: rtl/gfrs_if.sv
interface gfrs_req_if;
   logic                                valid;
   logic                                ready;
   logic [gfrs_pkg::FUNC_W-1:0]         func;
   logic signed [gfrs_pkg::VALUE_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink (input valid, input func, input value, output ready);
endinterface

interface gfrs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gfrs_pkg::FORCE_W-1:0]  force_cmd;
   logic [gfrs_pkg::STATUS_W-1:0] status;
   logic                          last;

   modport source (output valid, output force_cmd, output status, output last, input ready);
   modport sink (input valid, input force_cmd, input status, input last, output ready);
endinterface

// File: rtl/grasp_force_ramp_sequencer_top.sv
// Gripper force sequencer: takes start, grip sample, normal force sample, tick and preempt
// commands and produces the force command stream (unsigned Q15.16 newtons) with running,
// succeeded or preempted status. One command is taken per clock cycle while the result
// queue has room; a registered command is processed and its results are written into
// the queue. A command makes up to two results and the result channel moves one per
// cycle while the receiver is ready, so a tick that ends a ramp occupies the output for
// two results. The result queue holds RSP_DEPTH entries (at least 2); commands stall
// while it has room for fewer than two more results. The user must write registers
// through the csr port only while no command is in flight; the block does not enforce it.
module grasp_force_ramp_sequencer_top #(
   parameter int RSP_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   gfrs_req_if.sink                       req_chan,
   gfrs_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [gfrs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gfrs_pkg::FORCE_W-1:0]   csr_wdata
);

   gfrs_pkg::rsp_push_type push;
   logic                   space_ok;

   gfrs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .space_ok  (space_ok),
      .push      (push)
   );

   gfrs_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: rtl/gfrs_core.sv
module gfrs_core (
   input  logic                             clock,
   input  logic                             reset,
   gfrs_req_if.sink                         req_chan,
   input  logic                             csr_we,
   input  logic [gfrs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gfrs_pkg::FORCE_W-1:0]     csr_wdata,
   input  logic                             space_ok,
   output gfrs_pkg::rsp_push_type           push
);

   localparam int FW = gfrs_pkg::FORCE_W;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_WAIT    = 2'd1;
   localparam logic [1:0] PH_CONTACT = 2'd2;
   localparam logic [1:0] PH_RAMP    = 2'd3;

   function automatic logic lacks_contact(input logic [FW-1:0] g, input logic [FW-1:0] n,
                                          input logic [FW-1:0] thr);
      logic [FW:0]   sum;
      logic [FW-1:0] diff;
      sum  = {1'b0, g} + {1'b0, n};
      diff = (g >= n) ? g - n : n - g;
      return (g < thr) || (sum < {1'b0, thr}) || (diff < thr);
   endfunction

   // input register
   logic                            in_valid_ff, in_valid_in;
   logic [gfrs_pkg::FUNC_W-1:0]     in_func_ff;
   logic [gfrs_pkg::VALUE_W-1:0]    in_value_ff;

   // configuration
   logic [FW-1:0] thr_cfg_ff, thr_cfg_in;
   logic [FW-1:0] cforce_ff, cforce_in;
   logic [FW-1:0] step_ff, step_in;

   // sequencer state
   logic [1:0]    phase_ff, phase_in;
   logic [FW-1:0] grip_ff, grip_in;
   logic [FW-1:0] normal_ff, normal_in;
   logic [1:0]    sv_ff, sv_in;
   logic [FW-1:0] goal_ff, goal_in;
   logic [FW-1:0] lthr_ff, lthr_in;
   logic [FW-1:0] start_ff, start_in;
   logic [FW:0]   dist_ff, dist_in;
   logic [FW:0]   elapsed_ff, elapsed_in;
   logic          down_ff, down_in;

   logic                         fire;
   logic [gfrs_pkg::VALUE_W-1:0] neg_value;
   logic [gfrs_pkg::VALUE_W-1:0] abs_value;
   logic [FW-1:0]                mag;
   logic                         lacks;
   logic [FW-1:0]                step_eff;
   logic [FW+1:0]                el_sum;
   logic [FW:0]                  el_next;
   logic [FW+1:0]                up_sum;
   logic [FW-1:0]                cmd;

   assign fire           = in_valid_ff && space_ok;
   assign req_chan.ready = !in_valid_ff || fire;
   assign in_valid_in    = req_chan.ready ? req_chan.valid : in_valid_ff;

   // magnitude, the most negative code saturates
   assign neg_value = ~in_value_ff + 1'b1;
   assign abs_value = in_value_ff[gfrs_pkg::VALUE_W-1] ? neg_value : in_value_ff;
   assign mag       = abs_value[gfrs_pkg::VALUE_W-1] ? gfrs_pkg::MAX_FORCE
                                                     : abs_value[FW-1:0];

   // samples take effect before the contact test of the same item
   assign grip_in   = (fire && in_func_ff == gfrs_pkg::FUNC_GRIP) ? mag : grip_ff;
   assign normal_in = (fire && in_func_ff == gfrs_pkg::FUNC_NORMAL) ? mag : normal_ff;
   assign lacks     = lacks_contact(grip_in, normal_in, lthr_ff);

   assign step_eff = (step_ff == '0) ? {{(FW-1){1'b0}}, 1'b1} : step_ff;
   assign el_sum   = {1'b0, elapsed_ff} + {2'b00, step_eff};
   assign el_next  = el_sum[FW+1] ? {(FW+1){1'b1}} : el_sum[FW:0];
   assign up_sum   = {2'b00, start_ff} + {1'b0, el_next};

   always_comb begin
      if (down_ff) begin
         cmd = (el_next >= {1'b0, start_ff}) ? '0 : start_ff - el_next[FW-1:0];
      end else begin
         cmd = (up_sum > {2'b00, gfrs_pkg::MAX_FORCE}) ? gfrs_pkg::MAX_FORCE
                                                      : up_sum[FW-1:0];
      end
   end

   always_comb begin
      thr_cfg_in = thr_cfg_ff;
      cforce_in  = cforce_ff;
      step_in    = step_ff;
      if (csr_we) begin
         unique case (csr_index)
            gfrs_pkg::CSR_CONTACT_THRESHOLD: thr_cfg_in = csr_wdata;
            gfrs_pkg::CSR_CONTACT_FORCE:     cforce_in  = csr_wdata;
            gfrs_pkg::CSR_RAMP_STEP:         step_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      sv_in      = sv_ff;
      goal_in    = goal_ff;
      lthr_in    = lthr_ff;
      start_in   = start_ff;
      dist_in    = dist_ff;
      elapsed_in = elapsed_ff;
      down_in    = down_ff;
      push       = '0;

      if (fire) begin
         unique case (in_func_ff)
            gfrs_pkg::FUNC_START: begin
               goal_in  = mag;
               sv_in    = 2'b00;
               lthr_in  = (mag < thr_cfg_ff) ? mag : thr_cfg_ff;
               phase_in = PH_WAIT;
            end
            gfrs_pkg::FUNC_GRIP, gfrs_pkg::FUNC_NORMAL: begin
               sv_in = sv_ff | ((in_func_ff == gfrs_pkg::FUNC_GRIP) ? 2'b01 : 2'b10);
               if (phase_ff == PH_WAIT && sv_in == 2'b11) begin
                  if (lacks && grip_in < goal_ff) begin
                     phase_in = PH_CONTACT;
                  end else begin
                     phase_in   = PH_RAMP;
                     start_in   = grip_in;
                     down_in    = goal_ff < grip_in;
                     dist_in    = {1'b0, (goal_ff < grip_in) ? grip_in - goal_ff
                                                             : goal_ff - grip_in};
                     elapsed_in = '0;
                  end
               end
            end
            gfrs_pkg::FUNC_TICK: begin
               unique case (phase_ff)
                  PH_CONTACT: begin
                     push.count = 2'd1;
                     push.first.status = gfrs_pkg::STATUS_RUNNING;
                     push.first.last   = 1'b1;
                     if (lacks) begin
                        push.first.force_cmd = cforce_ff;
                     end else begin
                        push.first.force_cmd = lthr_ff;
                        phase_in   = PH_RAMP;
                        start_in   = grip_ff;
                        down_in    = goal_ff < grip_ff;
                        dist_in    = {1'b0, (goal_ff < grip_ff) ? grip_ff - goal_ff
                                                                : goal_ff - grip_ff};
                        elapsed_in = '0;
                     end
                  end
                  PH_RAMP: begin
                     elapsed_in = el_next;
                     push.first.force_cmd = cmd;
                     push.first.status    = gfrs_pkg::STATUS_RUNNING;
                     if (el_next > dist_ff) begin
                        push.count            = 2'd2;
                        push.first.last       = 1'b0;
                        push.second.force_cmd = goal_ff;
                        push.second.status    = gfrs_pkg::STATUS_SUCCEEDED;
                        push.second.last      = 1'b1;
                        phase_in              = PH_IDLE;
                     end else begin
                        push.count      = 2'd1;
                        push.first.last = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            gfrs_pkg::FUNC_PREEMPT: begin
               if (phase_ff != PH_IDLE) begin
                  push.count           = 2'd1;
                  push.first.force_cmd = '0;
                  push.first.status    = gfrs_pkg::STATUS_PREEMPTED;
                  push.first.last      = 1'b1;
                  phase_in             = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_func_ff  <= req_chan.func;
         in_value_ff <= req_chan.value;
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         thr_cfg_ff  <= gfrs_pkg::RST_CONTACT_THRESHOLD;
         cforce_ff   <= gfrs_pkg::RST_CONTACT_FORCE;
         step_ff     <= gfrs_pkg::RST_RAMP_STEP;
         grip_ff     <= '0;
         normal_ff   <= '0;
         goal_ff     <= '0;
         lthr_ff     <= '0;
         start_ff    <= '0;
         dist_ff     <= '0;
         elapsed_ff  <= '0;
         down_ff     <= 1'b0;
         sv_ff       <= 2'b00;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         thr_cfg_ff  <= thr_cfg_in;
         cforce_ff   <= cforce_in;
         step_ff     <= step_in;
         grip_ff     <= grip_in;
         normal_ff   <= normal_in;
         goal_ff     <= goal_in;
         lthr_ff     <= lthr_in;
         start_ff    <= start_in;
         dist_ff     <= dist_in;
         elapsed_ff  <= elapsed_in;
         down_ff     <= down_in;
         sv_ff       <= sv_in;
      end
   end

endmodule

// File: rtl/gfrs_rsp_fifo.sv
module gfrs_rsp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gfrs_pkg::rsp_push_type push,
   output logic                   space_ok,
   gfrs_rsp_if.source             rsp_chan
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   gfrs_pkg::rsp_item_type mem_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_plus1;
   logic             pop;

   assign wr_ptr_plus1 = next_ptr(wr_ptr_ff);
   assign space_ok     = count_ff <= ROOM_MAX;

   assign rsp_chan.valid     = count_ff != '0;
   assign rsp_chan.force_cmd = mem_ff[rd_ptr_ff].force_cmd;
   assign rsp_chan.status    = mem_ff[rd_ptr_ff].status;
   assign rsp_chan.last      = mem_ff[rd_ptr_ff].last;
   assign pop                = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_plus1;
         2'd2:    wr_ptr_in = next_ptr(wr_ptr_plus1);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_plus1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
